>>> hw/rtl/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared widths, controller states and the mark memory request bundle.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int LIMIT_W   = 16;
    localparam int COUNT_W   = 13;
    localparam int ADDR_W    = 16;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int BASE_W    = 9;                 // bases run up to 256
    localparam int SQ_W      = 17;                // squares up to 65536
    localparam int IDX_W     = 17;                // walk index, may pass the limit

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_FILL     = 7'b0000010,
        S_BASE_RD  = 7'b0000100,
        S_BASE_CHK = 7'b0001000,
        S_CROSS    = 7'b0010000,
        S_COUNT    = 7'b0100000,
        S_DONE     = 7'b1000000
    } spc_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mark_req_t;

endpackage

>>> hw/rtl/spc_mark_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_mark_ram
// One-bit mark store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spc_mark_ram
    import spc_pkg::*;
(
    input  logic      aclk,
    input  mark_req_t req,
    output logic      rdata
);

    logic mem [MEM_DEPTH];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/spc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_ctrl
// Sequencer for fill, base test, crossing off and counting over the marks.
// ----------------------------------------------------------------------------
module spc_ctrl
    import spc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [LIMIT_W-1:0] start_limit,
    output logic               idle,
    output logic               res_valid,
    output logic [COUNT_W-1:0] res_count,
    input  logic               res_take,
    output mark_req_t          mem_req,
    input  logic               mem_rdata
);

    spc_state_t         state_reg, state_next;
    logic [LIMIT_W-1:0] lim_reg, lim_next;
    logic [BASE_W-1:0]  p_reg, p_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   lim_ext;
    logic [SQ_W-1:0]    sq_step;

    assign lim_ext = IDX_W'(lim_reg);
    // (p+1)^2 = p^2 + 2p + 1
    assign sq_step = sq_reg + SQ_W'({p_reg, 1'b1});

    always_comb begin
        state_next = state_reg;
        lim_next   = lim_reg;
        p_next     = p_reg;
        sq_next    = sq_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        mem_req    = '0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    lim_next   = start_limit;
                    idx_next   = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg[ADDR_W-1:0];
                mem_req.wdata = (idx_reg >= IDX_W'(2));
                idx_next      = idx_reg + IDX_W'(1);
                if (idx_reg == lim_ext) begin
                    p_next     = BASE_W'(2);
                    sq_next    = SQ_W'(4);
                    state_next = S_BASE_RD;
                end
            end
            S_BASE_RD: begin
                if (sq_reg > SQ_W'(lim_reg)) begin
                    idx_next   = IDX_W'(2);
                    cnt_next   = '0;
                    state_next = S_COUNT;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ADDR_W'(p_reg);
                    state_next    = S_BASE_CHK;
                end
            end
            S_BASE_CHK: begin
                if (mem_rdata) begin
                    idx_next   = IDX_W'(sq_reg);
                    state_next = S_CROSS;
                end else begin
                    p_next     = p_reg + BASE_W'(1);
                    sq_next    = sq_step;
                    state_next = S_BASE_RD;
                end
            end
            S_CROSS: begin
                if (idx_reg <= lim_ext) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = idx_reg[ADDR_W-1:0];
                    mem_req.wdata = 1'b0;
                    idx_next      = idx_reg + IDX_W'(p_reg);
                end else begin
                    p_next     = p_reg + BASE_W'(1);
                    sq_next    = sq_step;
                    state_next = S_BASE_RD;
                end
            end
            S_COUNT: begin
                if (pend_reg && mem_rdata) begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
                if (idx_reg <= lim_ext) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_reg + IDX_W'(1);
                    pend_next     = 1'b1;
                end else if (!pend_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
        lim_reg <= lim_next;
        p_reg   <= p_next;
        sq_reg  <= sq_next;
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_count = cnt_reg;

`ifndef SYNTHESIS
    // the mark memory never sees a read and a write in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.we && mem_req.re))
        else $error("mark memory read and write overlap");

    // a crossing-off write always lands above the base being sieved
    a_cross_above_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CROSS && mem_req.we) |-> (idx_reg > IDX_W'(p_reg)))
        else $error("crossing off at or below its base");

    // outstanding count reads only occur during the count walk
    a_pend_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == S_COUNT))
        else $error("stray pending read");

    // the number of primes never exceeds the limit itself
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (LIMIT_W'(res_count) <= lim_reg))
        else $error("prime count above limit");
`endif

endmodule

>>> hw/rtl/sieve_prime_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sieve_prime_counter
// Counts the primes at or below a 16-bit limit with a sieve over a mark RAM.
// ----------------------------------------------------------------------------
//  channel  | ports                          | direction
//  ---------+--------------------------------+----------
//  request  | s_valid s_ready s_limit        | in
//  result   | m_valid m_ready m_prime_count  | out
//
//  A request fills the marks up to the limit, reads each base up to
//  sqrt(limit), crosses off the multiples of each base that is still
//  marked and then walks the marks to count them, one mark RAM access
//  at a time. Requests are worked one at a time; a new one is taken
//  while the previous result still waits in the output register.
//  The mark RAM has no reset and no clearing pass: each request fills it first.
// ----------------------------------------------------------------------------
module sieve_prime_counter
    import spc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [LIMIT_W-1:0] s_limit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_prime_count
);

    mark_req_t          mem_req;
    logic               mem_rdata;
    logic               ctrl_idle;
    logic               res_valid;
    logic [COUNT_W-1:0] res_count;
    logic               res_take;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_count_reg;

    spc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_valid && s_ready),
        .start_limit (s_limit),
        .idle        (ctrl_idle),
        .res_valid   (res_valid),
        .res_count   (res_count),
        .res_take    (res_take),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    spc_mark_ram u_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign s_ready  = ctrl_idle;
    // result moves to the output register once that register is free or being read out
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_take) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_take) begin
            m_count_reg <= res_count;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_prime_count = m_count_reg;

endmodule
